### src/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared constants and types for the TLB page table translator
// Field widths, parameter defaults and the outcome codes of a result word.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int unsigned VA_W      = 16;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned COUNT_W   = 32;

  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_COUNT_DEF  = 256;
  localparam int unsigned OFFSET_BITS_DEF = 8;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_PT_HIT  = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_t;

endpackage

### src/tpt_tlb.sv
// ----------------------------------------------------------------------------
// tpt_tlb: FIFO translation buffer
// Shift-register entries, newest in slot 0, with one indexed read port.
// ----------------------------------------------------------------------------
module tpt_tlb #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned PAGE_W  = 8,
  parameter int unsigned FRAME_W = 8,
  parameter int unsigned IDX_W   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic               rd_valid,
  output logic [PAGE_W-1:0]  rd_page,
  output logic [FRAME_W-1:0] rd_frame,
  input  logic               push,
  input  logic [PAGE_W-1:0]  push_page,
  input  logic [FRAME_W-1:0] push_frame
);

  logic [ENTRIES-1:0] valid_r;
  logic [PAGE_W-1:0]  page_r  [ENTRIES];
  logic [FRAME_W-1:0] frame_r [ENTRIES];

  // valid bits clear on reset; everything moves one slot older on a push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (push) begin
      for (int i = ENTRIES - 1; i > 0; i--) begin
        valid_r[i] <= valid_r[i-1];
      end
      valid_r[0] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = ENTRIES - 1; i > 0; i--) begin
        page_r[i]  <= page_r[i-1];
        frame_r[i] <= frame_r[i-1];
      end
      page_r[0]  <= push_page;
      frame_r[0] <= push_frame;
    end
  end

  assign rd_valid = valid_r[rd_idx];
  assign rd_page  = page_r[rd_idx];
  assign rd_frame = frame_r[rd_idx];

endmodule

### src/tpt_page_table.sv
// ----------------------------------------------------------------------------
// tpt_page_table: page table memory
// One valid bit and a frame per page, registered read, swept clear after reset.
// ----------------------------------------------------------------------------
module tpt_page_table #(
  parameter int unsigned PAGE_COUNT = 256,
  parameter int unsigned PAGE_W     = 8,
  parameter int unsigned FRAME_W    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               ready,
  input  logic               wr_en,
  input  logic [PAGE_W-1:0]  wr_addr,
  input  logic [FRAME_W-1:0] wr_frame,
  input  logic [PAGE_W-1:0]  rd_addr,
  output logic               rd_valid,
  output logic [FRAME_W-1:0] rd_frame
);

  logic [FRAME_W:0]  mem [PAGE_COUNT];
  logic [FRAME_W:0]  rd_data_r;
  logic              clearing_r;
  logic [PAGE_W-1:0] clr_addr_r;

  // walk every row once after reset, writing it invalid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == PAGE_W'(PAGE_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_frame};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign ready    = !clearing_r;
  assign rd_valid = rd_data_r[FRAME_W];
  assign rd_frame = rd_data_r[FRAME_W-1:0];

endmodule

### src/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator: TLB lookup with page table and demand paging
// Sequence: a TLB hit in slot k ends the scan at that slot; a miss scans every
//   slot and then takes the page table result, with a remainder reduction
//   first when PAGE_COUNT is smaller than the page space (none at the defaults).
// Throughput: a word is taken only in idle, after the last is done; the TLB
//   scan takes one entry per cycle through one compare. The receiver cannot stall.
// Reset: synchronous; the page table is swept clear row by row after reset,
//   and busy stays high until the cycle after the sweep ends.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tpt_pkg::VA_W-1:0]      in_virtual_address,
  output logic                          out_valid,
  output logic [tpt_pkg::VA_W-1:0]      out_physical_address,
  output logic [tpt_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [tpt_pkg::COUNT_W-1:0]   out_tlb_hit_total,
  output logic [tpt_pkg::COUNT_W-1:0]   out_fault_total
);

  localparam int unsigned VA_W     = tpt_pkg::VA_W;
  localparam int unsigned VPN_W    = VA_W - OFFSET_BITS;
  localparam int unsigned PAGE_W   = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W  = (VPN_W > 0) ? VPN_W : 1;
  localparam int unsigned IDX_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned RED_LAST = 2;
  // scaled reciprocal of the page count; the quotient estimate is at most one low
  localparam int unsigned RECIP    = (1 << VA_W) / PAGE_COUNT;
  // page numbers wrap modulo PAGE_COUNT only when the address names more pages
  localparam bit          NEED_MOD = ((1 << VPN_W) > PAGE_COUNT);

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_REDUCE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_TABLE  = 5'b10000
  } st_t;

  st_t                         state_r, state_nxt;
  logic [PAGE_W:0]             rem_r, rem_nxt;
  logic [VA_W-1:0]             vpn_r;
  logic [VA_W-1:0]             quo_r;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [OFFSET_BITS-1:0]      offset_r;
  logic [FRAME_W-1:0]          next_free_r;
  logic [tpt_pkg::COUNT_W-1:0] hit_cnt_r, fault_cnt_r;
  logic                        out_valid_r;
  logic [VA_W-1:0]             out_pa_r;
  logic [tpt_pkg::OUTCOME_W-1:0] out_outcome_r;

  logic [PAGE_W-1:0]  page;
  logic [2*VA_W-1:0]  quo_prod, quo_back;
  logic [VA_W-1:0]    red_diff;
  logic [PAGE_W:0]    red_out;
  logic               tlb_rd_valid;
  logic [PAGE_W-1:0]  tlb_rd_page;
  logic [FRAME_W-1:0] tlb_rd_frame;
  logic               tlb_match;
  logic               pt_ready, pt_rd_valid;
  logic [FRAME_W-1:0] pt_rd_frame;

  logic               res_valid, push, pt_we, count_hit, count_fault;
  logic [FRAME_W-1:0] res_frame;
  tpt_pkg::outcome_t  res_outcome;

  assign page = rem_r[PAGE_W-1:0];

  // page-number modulo: estimate the quotient by reciprocal, back it out,
  // then fix the remainder with one compare and subtract
  assign quo_prod = {{VA_W{1'b0}}, vpn_r} * (2*VA_W)'(RECIP);
  assign quo_back = {{VA_W{1'b0}}, quo_r} * (2*VA_W)'(PAGE_COUNT);
  assign red_diff = vpn_r - quo_back[VA_W-1:0];
  assign red_out  = (rem_r >= (PAGE_W+1)'(PAGE_COUNT)) ?
                    rem_r - (PAGE_W+1)'(PAGE_COUNT) : rem_r;

  assign tlb_match = tlb_rd_valid && (tlb_rd_page == page);

  tpt_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .PAGE_W  (PAGE_W),
    .FRAME_W (FRAME_W),
    .IDX_W   (IDX_W)
  ) u_tlb (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_idx     (idx_r),
    .rd_valid   (tlb_rd_valid),
    .rd_page    (tlb_rd_page),
    .rd_frame   (tlb_rd_frame),
    .push       (push),
    .push_page  (page),
    .push_frame (res_frame)
  );

  // the read address is the page register, so the registered data is ready
  // by the cycle after the scan ends
  tpt_page_table #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_W     (PAGE_W),
    .FRAME_W    (FRAME_W)
  ) u_page_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ready    (pt_ready),
    .wr_en    (pt_we),
    .wr_addr  (page),
    .wr_frame (next_free_r),
    .rd_addr  (page),
    .rd_valid (pt_rd_valid),
    .rd_frame (pt_rd_frame)
  );

  always_comb begin
    state_nxt   = state_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    idx_nxt     = idx_r;
    res_valid   = 1'b0;
    res_frame   = tlb_rd_frame;
    res_outcome = tpt_pkg::OUT_TLB_HIT;
    push        = 1'b0;
    pt_we       = 1'b0;
    count_hit   = 1'b0;
    count_fault = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // hold off input words until the page table sweep is done
        if (pt_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          idx_nxt  = '0;
          step_nxt = STEP_W'(RED_LAST);
          if (NEED_MOD) begin
            rem_nxt   = '0;
            state_nxt = ST_REDUCE;
          end else begin
            rem_nxt   = (PAGE_W+1)'(in_virtual_address >> OFFSET_BITS);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_REDUCE: begin
        // wait for the quotient, take the raw remainder, then correct it
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          rem_nxt = red_diff[PAGE_W:0];
        end else if (step_r == '0) begin
          rem_nxt   = red_out;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // compare one TLB slot per cycle, newest first; first match wins
        if (tlb_match) begin
          res_valid = 1'b1;
          count_hit = 1'b1;
          state_nxt = ST_IDLE;
        end else if (idx_r == IDX_W'(TLB_ENTRIES - 1)) begin
          state_nxt = ST_TABLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TABLE: begin
        // TLB miss: take the page table entry, or map the page to a new frame
        res_valid = 1'b1;
        push      = 1'b1;
        state_nxt = ST_IDLE;
        if (pt_rd_valid) begin
          res_outcome = tpt_pkg::OUT_PT_HIT;
          res_frame   = pt_rd_frame;
        end else begin
          res_outcome = tpt_pkg::OUT_FAULT;
          res_frame   = next_free_r;
          pt_we       = 1'b1;
          count_fault = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      next_free_r <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_valid;
      if (count_hit && (hit_cnt_r != '1)) begin
        hit_cnt_r <= hit_cnt_r + 1'b1;
      end
      if (count_fault) begin
        // frames are handed out round-robin; a single frame stays at zero
        next_free_r <= (VPN_W > 0) ? next_free_r + 1'b1 : '0;
        if (fault_cnt_r != '1) begin
          fault_cnt_r <= fault_cnt_r + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    quo_r  <= quo_prod[2*VA_W-1:VA_W];
    if (state_r == ST_IDLE && start) begin
      vpn_r    <= in_virtual_address >> OFFSET_BITS;
      offset_r <= in_virtual_address[OFFSET_BITS-1:0];
    end
    if (res_valid) begin
      out_pa_r      <= VA_W'({res_frame, offset_r});
      out_outcome_r <= res_outcome;
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_outcome          = out_outcome_r;
  assign out_tlb_hit_total    = hit_cnt_r;
  assign out_fault_total      = fault_cnt_r;

endmodule

### src/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker: port-level checks for the TLB page table translator
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module tpt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [tpt_pkg::OUTCOME_W-1:0] out_outcome,
  input logic [tpt_pkg::COUNT_W-1:0]   out_tlb_hit_total,
  input logic [tpt_pkg::COUNT_W-1:0]   out_fault_total
);

  // an accepted word raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  // no two result words in consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // totals move only together with a result word
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid |->
      $stable(out_tlb_hit_total) && $stable(out_fault_total))
    else $error("running totals changed without a result");

  // a hit result counts itself, and never bumps the fault total
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == tpt_pkg::OUT_TLB_HIT |->
      out_tlb_hit_total != '0 && $stable(out_fault_total))
    else $error("TLB hit not reflected in totals");

  // a fault result counts itself, and never bumps the hit total
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == tpt_pkg::OUT_FAULT |->
      out_fault_total != '0 && $stable(out_tlb_hit_total))
    else $error("page fault not reflected in totals");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_outcome       (out_outcome),
  .out_tlb_hit_total (out_tlb_hit_total),
  .out_fault_total   (out_fault_total)
);
